// ===== rtl/frp_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// frp_pkg
// Shared types and constants of the first-fit row packer.
// ----------------------------------------------------------------------------
package frp_pkg;

  localparam int MAX_ROWS_DEF = 256;

  localparam logic [31:0] LEFT_RESET  = 32'd1215752191;
  localparam logic [31:0] RIGHT_RESET = 32'd0;
  localparam logic [31:0] ROW_NONE    = 32'hFFFF_FFFF;
  localparam logic [31:0] ROW_FILT    = 32'hFFFF_FFFE;

  localparam logic OP_PLACE = 1'b0;
  localparam logic OP_CLEAR = 1'b1;

  localparam logic [2:0] CFG_LEVELS      = 3'd0;
  localparam logic [2:0] CFG_VIEW_OFFSET = 3'd1;
  localparam logic [2:0] CFG_JOIN_LEFT   = 3'd2;
  localparam logic [2:0] CFG_LENGTH_MODE = 3'd3;
  localparam logic [2:0] CFG_LENGTH_CAP  = 3'd4;

  typedef struct packed {
    logic [8:0]  levels_in_use;
    logic [7:0]  view_offset;
    logic        join_left;
    logic        length_mode;
    logic [30:0] length_cap;
  } frp_cfg_t;

  typedef struct packed {
    logic signed [31:0] row;
    logic               placed;
    logic [7:0]         table_row;
  } frp_result_t;

  typedef struct packed {
    logic signed [31:0] left;
    logic signed [31:0] right;
  } frp_bounds_t;

endpackage
`default_nettype wire

// ===== rtl/frp_row_mem.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// frp_row_mem
// Row bounds table: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module frp_row_mem #(
  parameter int DEPTH  = 256,
  parameter int ADDR_W = 8
) (
  input  wire logic                  clk,
  input  wire logic                  we,
  input  wire logic [ADDR_W-1:0]     waddr,
  input  wire frp_pkg::frp_bounds_t  wdata,
  input  wire logic                  re,
  input  wire logic [ADDR_W-1:0]     raddr,
  output frp_pkg::frp_bounds_t       rdata
);
  import frp_pkg::*;

  frp_bounds_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

// ===== rtl/frp_ctrl.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// frp_ctrl
// Sequencer: clearing sweep, first-fit scan over the row table with one
// read a cycle, write-back of the widened bounds, result formation.
// ----------------------------------------------------------------------------
module frp_ctrl #(
  parameter int MAX_ROWS = frp_pkg::MAX_ROWS_DEF,
  parameter int IDX_W    = 8,
  parameter int CNT_W    = 9
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire frp_pkg::frp_cfg_t     cfg,
  input  wire logic                  in_valid,
  output logic                       in_ready,
  input  wire logic                  operation,
  input  wire logic signed [31:0]    span_start,
  input  wire logic signed [31:0]    span_end,
  input  wire logic                  filtered,
  input  wire logic [30:0]           template_length,
  output logic                       res_valid,
  output frp_pkg::frp_result_t       res,
  input  wire logic                  res_take,
  output logic                       mem_we,
  output logic [IDX_W-1:0]           mem_waddr,
  output frp_pkg::frp_bounds_t       mem_wdata,
  output logic                       mem_re,
  output logic [IDX_W-1:0]           mem_raddr,
  input  wire frp_pkg::frp_bounds_t  mem_rdata
);
  import frp_pkg::*;

  typedef enum logic [1:0] {S_CLEAR, S_IDLE, S_SCAN, S_RESULT} state_t;

  localparam logic [IDX_W-1:0] LAST_ROW = IDX_W'(MAX_ROWS - 1);

  state_t             state;
  logic [IDX_W-1:0]   clr_addr;
  logic               clr_report;
  logic [CNT_W-1:0]   scan_addr;
  logic [CNT_W-1:0]   n_lim;
  logic               pend;
  logic [IDX_W-1:0]   pend_idx;
  logic signed [31:0] s_start;
  logic signed [31:0] s_end;

  logic               accept;
  logic [CNT_W-1:0]   n_next;
  logic               fit;
  frp_bounds_t        upd;
  logic [31:0]        idx32;
  logic [31:0]        off32;
  logic [31:0]        hit_row;
  logic [30:0]        clamped;

  assign in_ready  = (state == S_IDLE);
  assign accept    = in_valid && in_ready;
  assign res_valid = (state == S_RESULT);

  assign n_next = ({23'd0, cfg.levels_in_use} > 32'(MAX_ROWS)) ?
                  CNT_W'(MAX_ROWS) : CNT_W'(cfg.levels_in_use);

  assign clamped = (template_length < cfg.length_cap) ? template_length : cfg.length_cap;

  always_comb begin
    if (cfg.join_left) begin
      fit       = s_end < mem_rdata.left;
      upd.left  = s_start;
      upd.right = (mem_rdata.right < s_end) ? s_end : mem_rdata.right;
    end else begin
      fit       = mem_rdata.right < s_start;
      upd.right = s_end;
      upd.left  = (s_start < mem_rdata.left) ? s_start : mem_rdata.left;
    end
  end

  assign idx32   = 32'(pend_idx);
  assign off32   = 32'(cfg.view_offset);
  assign hit_row = (idx32 >= off32) ? (idx32 - off32) : ROW_NONE;

  always_comb begin
    mem_re    = (state == S_SCAN) && (scan_addr < n_lim);
    mem_raddr = scan_addr[IDX_W-1:0];
    if (state == S_CLEAR) begin
      mem_we    = 1'b1;
      mem_waddr = clr_addr;
      mem_wdata = '{left: LEFT_RESET, right: RIGHT_RESET};
    end else begin
      mem_we    = (state == S_SCAN) && pend && fit;
      mem_waddr = pend_idx;
      mem_wdata = upd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_CLEAR;
      clr_addr   <= '0;
      clr_report <= 1'b0;
      pend       <= 1'b0;
    end else begin
      case (state)
        S_CLEAR: begin
          if (clr_addr == LAST_ROW) begin
            res   <= '{row: ROW_NONE, placed: 1'b0, table_row: 8'd0};
            state <= clr_report ? S_RESULT : S_IDLE;
          end else begin
            clr_addr <= clr_addr + 1'b1;
          end
        end
        S_IDLE: begin
          if (accept) begin
            s_start   <= span_start;
            s_end     <= span_end;
            n_lim     <= n_next;
            scan_addr <= '0;
            pend      <= 1'b0;
            if (operation == OP_CLEAR) begin
              clr_addr   <= '0;
              clr_report <= 1'b1;
              state      <= S_CLEAR;
            end else if (cfg.length_mode) begin
              res   <= '{row: {1'b0, clamped}, placed: 1'b0, table_row: 8'd0};
              state <= S_RESULT;
            end else if (filtered) begin
              res   <= '{row: ROW_FILT, placed: 1'b0, table_row: 8'd0};
              state <= S_RESULT;
            end else if (n_next == '0) begin
              res   <= '{row: ROW_NONE, placed: 1'b0, table_row: 8'd0};
              state <= S_RESULT;
            end else begin
              res   <= '{row: ROW_NONE, placed: 1'b0, table_row: 8'd0};
              state <= S_SCAN;
            end
          end
        end
        S_SCAN: begin
          if (mem_re) begin
            scan_addr <= scan_addr + 1'b1;
            pend_idx  <= scan_addr[IDX_W-1:0];
          end
          pend <= mem_re;
          if (pend && fit) begin
            res   <= '{row: hit_row, placed: 1'b1, table_row: idx32[7:0]};
            state <= S_RESULT;
          end else if (pend && !mem_re) begin
            state <= S_RESULT;
          end
        end
        S_RESULT: begin
          if (res_take) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule
`default_nettype wire

// ===== rtl/first_fit_row_packer.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// first_fit_row_packer
// First-fit display row assignment for genomic intervals.
//
// Input channel (in_valid/in_ready) takes one item a beat: place an interval
// or clear the row table. Output channel (out_valid/out_ready) returns one
// result beat per item: row, placed flag and table row index.
// Configuration is written through cfg_write/cfg_index/cfg_data; the user
// must write it only while idle, which the block itself does not enforce.
// Row bounds live in a MAX_ROWS-entry memory with registered read data.
// A place item scans one table row a cycle, in order from row 0: the first
// row whose bounds fit takes the interval and delivers its result; a miss
// delivers it once n rows are searched (n = rows searched, up to MAX_ROWS).
// Filtered items, length mode and zero rows searched skip the scan.
// A clear item sweeps the whole memory. After reset the same sweep runs
// with in_ready low; configuration writes are taken throughout.
// One item is in work at a time. A registered output stage holds a finished
// result while the receiver stalls, and the next item is accepted meanwhile;
// its own result waits until that stage frees.
// ----------------------------------------------------------------------------
module first_fit_row_packer #(
  parameter int MAX_ROWS = frp_pkg::MAX_ROWS_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic               operation,
  input  wire logic signed [31:0] span_start,
  input  wire logic signed [31:0] span_end,
  input  wire logic               filtered,
  input  wire logic [30:0]        template_length,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic signed [31:0]      row,
  output logic                    placed,
  output logic [7:0]              table_row,
  input  wire logic               cfg_write,
  input  wire logic [2:0]         cfg_index,
  input  wire logic [30:0]        cfg_data
);
  import frp_pkg::*;

  localparam int IDX_W = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int CNT_W = $clog2(MAX_ROWS + 1);

  frp_cfg_t         cfg;
  logic             res_valid;
  frp_result_t      res;
  logic             res_take;
  logic             mem_we;
  logic [IDX_W-1:0] mem_waddr;
  frp_bounds_t      mem_wdata;
  logic             mem_re;
  logic [IDX_W-1:0] mem_raddr;
  frp_bounds_t      mem_rdata;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '{levels_in_use: 9'd256, view_offset: 8'd0, join_left: 1'b0,
               length_mode: 1'b0, length_cap: 31'd2000};
    end else if (cfg_write) begin
      case (cfg_index)
        CFG_LEVELS:      cfg.levels_in_use <= cfg_data[8:0];
        CFG_VIEW_OFFSET: cfg.view_offset   <= cfg_data[7:0];
        CFG_JOIN_LEFT:   cfg.join_left     <= cfg_data[0];
        CFG_LENGTH_MODE: cfg.length_mode   <= cfg_data[0];
        CFG_LENGTH_CAP:  cfg.length_cap    <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  frp_row_mem #(
    .DEPTH  (MAX_ROWS),
    .ADDR_W (IDX_W)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  frp_ctrl #(
    .MAX_ROWS (MAX_ROWS),
    .IDX_W    (IDX_W),
    .CNT_W    (CNT_W)
  ) u_ctrl (
    .clk             (clk),
    .rst             (rst),
    .cfg             (cfg),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .operation       (operation),
    .span_start      (span_start),
    .span_end        (span_end),
    .filtered        (filtered),
    .template_length (template_length),
    .res_valid       (res_valid),
    .res             (res),
    .res_take        (res_take),
    .mem_we          (mem_we),
    .mem_waddr       (mem_waddr),
    .mem_wdata       (mem_wdata),
    .mem_re          (mem_re),
    .mem_raddr       (mem_raddr),
    .mem_rdata       (mem_rdata)
  );

  // load the output stage when it is empty or its beat leaves this cycle
  assign res_take = res_valid && (!out_valid || out_ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_take) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_take) begin
      row       <= res.row;
      placed    <= res.placed;
      table_row <= res.table_row;
    end
  end

endmodule
`default_nettype wire

// ===== tb/row_assignment_checker.sv =====
// ----------------------------------------------------------------------------
// row_assignment_checker
// Watches the item, result and register ports of the first-fit row packer.
// Keeps its own copy of the row bounds and the register settings, works out
// the row each accepted item should get, and compares every result beat with
// the oldest expected one. Hands the mismatch count, the number of results
// still awaited, the results seen and those placed to the test top.
// ----------------------------------------------------------------------------
module row_assignment_checker #(
  parameter int MAX_ROWS = frp_pkg::MAX_ROWS_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  input  wire logic               in_ready,
  input  wire logic               operation,
  input  wire logic signed [31:0] span_start,
  input  wire logic signed [31:0] span_end,
  input  wire logic               filtered,
  input  wire logic [30:0]        template_length,
  input  wire logic               out_valid,
  input  wire logic               out_ready,
  input  wire logic signed [31:0] row,
  input  wire logic               placed,
  input  wire logic [7:0]         table_row,
  input  wire logic               cfg_write,
  input  wire logic [2:0]         cfg_index,
  input  wire logic [30:0]        cfg_data,
  output int                      mismatches,
  output int                      outstanding,
  output int                      results_seen,
  output int                      rows_taken
);
  import frp_pkg::*;

  frp_cfg_t           cfg;
  logic signed [31:0] row_left  [MAX_ROWS];
  logic signed [31:0] row_right [MAX_ROWS];
  frp_result_t        awaited_rows [$];
  int                 fail_count  = 0;
  int                 seen_count  = 0;
  int                 taken_count = 0;

  assign mismatches   = fail_count;
  assign results_seen = seen_count;
  assign rows_taken   = taken_count;

  function automatic void clear_rows();
    for (int r = 0; r < MAX_ROWS; r++) begin
      row_left[r]  = LEFT_RESET;
      row_right[r] = RIGHT_RESET;
    end
  endfunction

  function automatic frp_result_t assign_row(input logic op,
                                             input logic signed [31:0] s,
                                             input logic signed [31:0] e,
                                             input logic filt,
                                             input logic [30:0] tlen);
    frp_result_t res;
    int          n;
    int          hit;
    int          k;
    res.row       = ROW_NONE;
    res.placed    = 1'b0;
    res.table_row = '0;
    hit = -1;
    if (op == OP_CLEAR) begin
      clear_rows();
    end else if (cfg.length_mode) begin
      res.row = (tlen < cfg.length_cap) ? {1'b0, tlen} : {1'b0, cfg.length_cap};
    end else if (filt) begin
      res.row = ROW_FILT;
    end else begin
      n = (int'(cfg.levels_in_use) > MAX_ROWS) ? MAX_ROWS : int'(cfg.levels_in_use);
      for (k = 0; k < n && hit < 0; k++) begin
        if (!cfg.join_left) begin
          if (row_right[k] < s) begin
            row_right[k] = e;
            if (s < row_left[k]) row_left[k] = s;
            hit = k;
          end
        end else begin
          if (e < row_left[k]) begin
            row_left[k] = s;
            if (row_right[k] < e) row_right[k] = e;
            hit = k;
          end
        end
      end
      if (hit >= 0) begin
        res.placed    = 1'b1;
        res.table_row = hit[7:0];
        if (hit >= int'(cfg.view_offset)) res.row = hit - int'(cfg.view_offset);
      end
    end
    return res;
  endfunction

  always @(posedge clk) begin
    frp_result_t want;
    if (rst) begin
      cfg = '{levels_in_use: 9'd256, view_offset: 8'd0, join_left: 1'b0,
              length_mode: 1'b0, length_cap: 31'd2000};
      clear_rows();
      awaited_rows.delete();
    end else begin
      if (cfg_write) begin
        case (cfg_index)
          CFG_LEVELS:      cfg.levels_in_use = cfg_data[8:0];
          CFG_VIEW_OFFSET: cfg.view_offset   = cfg_data[7:0];
          CFG_JOIN_LEFT:   cfg.join_left     = cfg_data[0];
          CFG_LENGTH_MODE: cfg.length_mode   = cfg_data[0];
          CFG_LENGTH_CAP:  cfg.length_cap    = cfg_data;
          default: ;
        endcase
      end
      if (out_valid && out_ready) begin
        seen_count++;
        if (placed) taken_count++;
        if (awaited_rows.size() == 0) begin
          fail_count++;
          $display("%0t: unexpected result beat: row %0d placed %0b table_row %0d",
                   $time, row, placed, table_row);
        end else begin
          want = awaited_rows.pop_front();
          if (row !== want.row || placed !== want.placed || table_row !== want.table_row)
          begin
            fail_count++;
            $display("%0t: expected row %0d placed %0b table_row %0d,",
                     $time, want.row, want.placed, want.table_row,
                     " got row %0d placed %0b table_row %0d",
                     row, placed, table_row);
          end
        end
      end
      if (in_valid && in_ready)
        awaited_rows.insert(awaited_rows.size(),
                            assign_row(operation, span_start, span_end,
                                       filtered, template_length));
    end
    outstanding <= awaited_rows.size();
  end

endmodule

// ===== tb/first_fit_row_packer_test.sv =====
// ----------------------------------------------------------------------------
// first_fit_row_packer_test
// Stimulus and verdict for the first-fit row packer.
// A directed run covers field extremes, clears, filtered items, misses, rows
// scrolled above the view, zero and oversized row counts, both directions and
// length mode with its cap at the extremes. Random batches follow, mostly
// ordered interval streams with some noise, under changing register settings
// and varied sender gaps and receiver stalls. Results are checked beside the
// block by row_assignment_checker.
// ----------------------------------------------------------------------------
module first_fit_row_packer_test;
  import frp_pkg::*;

  localparam int CYCLE_LIMIT = 1_000_000;

  logic               clk             = 1'b0;
  logic               rst             = 1'b1;
  logic               in_valid        = 1'b0;
  logic               operation       = OP_PLACE;
  logic signed [31:0] span_start      = '0;
  logic signed [31:0] span_end        = '0;
  logic               filtered        = 1'b0;
  logic [30:0]        template_length = '0;
  logic               out_ready       = 1'b0;
  logic               cfg_write       = 1'b0;
  logic [2:0]         cfg_index       = CFG_LEVELS;
  logic [30:0]        cfg_data        = '0;
  logic               in_ready;
  logic               out_valid;
  logic signed [31:0] row;
  logic               placed;
  logic [7:0]         table_row;

  int mismatches;
  int outstanding;
  int results_seen;
  int rows_taken;
  int send_idle  = 0;
  int recv_stall = 0;
  int items_sent = 0;
  int cycles     = 0;

  first_fit_row_packer dut (.*);

  row_assignment_checker chk (.*);

  initial begin
    forever #4 clk = ~clk;
  end

  always @(posedge clk) out_ready <= ($urandom_range(99) >= recv_stall);

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  task automatic send_item(input logic op, input logic signed [31:0] s,
                           input logic signed [31:0] e, input logic filt,
                           input logic [30:0] tlen);
    if (send_idle > 0 && $urandom_range(99) < send_idle) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle);
    end
    in_valid        <= 1'b1;
    operation       <= op;
    span_start      <= s;
    span_end        <= e;
    filtered        <= filt;
    template_length <= tlen;
    do @(posedge clk); while (!in_ready);
    items_sent++;
  endtask

  // hold off until every awaited result beat has arrived
  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
    repeat (2) @(posedge clk);
  endtask

  task automatic write_config(input logic [8:0] levels, input logic [7:0] offset,
                              input logic jl, input logic lm, input logic [30:0] cap);
    drain();
    cfg_write <= 1'b1;
    cfg_index <= CFG_LEVELS;
    cfg_data  <= {22'd0, levels};
    @(posedge clk);
    cfg_index <= CFG_VIEW_OFFSET;
    cfg_data  <= {23'd0, offset};
    @(posedge clk);
    cfg_index <= CFG_JOIN_LEFT;
    cfg_data  <= {30'd0, jl};
    @(posedge clk);
    cfg_index <= CFG_LENGTH_MODE;
    cfg_data  <= {30'd0, lm};
    @(posedge clk);
    cfg_index <= CFG_LENGTH_CAP;
    cfg_data  <= cap;
    @(posedge clk);
    cfg_write <= 1'b0;
  endtask

  initial begin
    logic [8:0]         lv;
    logic [7:0]         off;
    logic               jl;
    logic               lm;
    logic [30:0]        cap;
    logic signed [31:0] cursor;
    logic signed [31:0] s;
    logic signed [31:0] e;
    logic [30:0]        tlen;
    int                 pick;
    int                 stride;
    int                 len;

    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // directed: rightward packing at reset settings
    send_item(OP_PLACE, 1, 10, 1'b0, 31'($urandom));
    send_item(OP_PLACE, 0, 5, 1'b0, 31'($urandom));
    send_item(OP_PLACE, 32'sh8000_0000, 32'sh7fff_ffff, 1'b0, 31'($urandom));
    send_item(OP_PLACE, 32'sh7fff_ffff, 32'sh8000_0000, 1'b0, 31'($urandom));
    send_item(OP_PLACE, 32'sh8000_0001, 0, 1'b0, 31'($urandom));
    send_item(OP_PLACE, 100, 200, 1'b1, 31'($urandom));
    send_item(OP_CLEAR, 32'sh7fff_ffff, 32'sh8000_0000, 1'b1, 31'h7fff_ffff);
    send_item(OP_PLACE, 5, -3, 1'b0, 31'($urandom));

    // rows scrolled above the view, then a miss over four rows
    write_config(9'd4, 8'd2, 1'b0, 1'b0, 31'd2000);
    for (int k = 1; k <= 5; k++) send_item(OP_PLACE, k * 10, 100, 1'b0, 31'($urandom));

    write_config(9'd0, 8'd0, 1'b1, 1'b0, 31'd2000);
    send_item(OP_PLACE, 1, 2, 1'b0, 31'($urandom));

    // leftward packing, row count beyond the table
    write_config(9'd511, 8'd0, 1'b1, 1'b0, 31'd2000);
    send_item(OP_CLEAR, 0, 0, 1'b0, '0);
    send_item(OP_PLACE, 50, 100, 1'b0, 31'($urandom));
    send_item(OP_PLACE, 40, 60, 1'b0, 31'($urandom));
    send_item(OP_PLACE, 0, 20, 1'b0, 31'($urandom));
    send_item(OP_PLACE, -10, 32'sh7fff_ffff, 1'b0, 31'($urandom));
    send_item(OP_PLACE, 32'sh7fff_ffff, 32'sh8000_0000, 1'b0, 31'($urandom));

    // length mode with the cap at default and both extremes
    write_config(9'd256, 8'd0, 1'b0, 1'b1, 31'd2000);
    send_item(OP_PLACE, 1, 2, 1'b0, 31'd0);
    send_item(OP_PLACE, 1, 2, 1'b0, 31'd1999);
    send_item(OP_PLACE, 1, 2, 1'b0, 31'd2000);
    send_item(OP_PLACE, 1, 2, 1'b1, 31'h7fff_ffff);
    send_item(OP_CLEAR, 1, 2, 1'b0, 31'd5);
    write_config(9'd256, 8'd0, 1'b0, 1'b1, 31'd0);
    send_item(OP_PLACE, 1, 2, 1'b0, 31'd7);
    write_config(9'd256, 8'd0, 1'b0, 1'b1, 31'h7fff_ffff);
    send_item(OP_PLACE, 1, 2, 1'b0, 31'h7fff_ffff);
    send_item(OP_PLACE, 1, 2, 1'b0, 31'h7fff_fffe);

    // random batches
    for (int b = 0; b < 12; b++) begin
      case (b % 4)
        0: begin send_idle = 0;  recv_stall = 0;  end
        1: begin send_idle = 74; recv_stall = 0;  end
        2: begin send_idle = 0;  recv_stall = 74; end
        default: begin send_idle = 20; recv_stall = 20; end
      endcase
      lv  = 9'($urandom_range(1, 40));
      off = 8'($urandom_range(0, 6));
      jl  = 1'($urandom_range(1));
      lm  = ($urandom_range(9) == 0);
      cap = 31'($urandom);
      case (b)
        0: begin lv = 9'd256; off = 8'd0;   jl = 1'b0; lm = 1'b0; end
        1: begin lv = 9'd16;  off = 8'd3;   jl = 1'b1; lm = 1'b0; end
        3: begin lv = 9'd511; off = 8'd255; jl = 1'b0; lm = 1'b0; end
        5: begin lv = 9'd1;   off = 8'd0;   jl = 1'b1; lm = 1'b0; end
        7: begin lm = 1'b1; cap = 31'($urandom_range(0, 1000)); end
        default: ;
      endcase
      write_config(lv, off, jl, lm, cap);
      send_item(OP_CLEAR, $urandom, $urandom, 1'($urandom_range(1)), 31'($urandom));
      cursor = jl ? $urandom_range(1000, 1_000_000_000) : $urandom_range(1, 1_000_000);
      for (int i = 0; i < 49; i++) begin
        if ($urandom_range(99) == 0) drain();
        pick = $urandom_range(99);
        tlen = $urandom_range(1) ? 31'($urandom) : 31'($urandom_range(0, 3000));
        if (pick < 3) begin
          send_item(OP_CLEAR, $urandom, $urandom, 1'($urandom_range(1)), tlen);
        end else if (pick < 15) begin
          send_item(OP_PLACE, $urandom, $urandom, 1'($urandom_range(1)), tlen);
        end else begin
          stride = $urandom_range(0, 40);
          len    = $urandom_range(0, 200);
          if (jl) begin
            cursor = cursor - stride;
            s = cursor - len;
            e = cursor;
          end else begin
            cursor = cursor + stride;
            s = cursor;
            e = cursor + len;
          end
          send_item(OP_PLACE, s, e, ($urandom_range(9) == 0), tlen);
        end
      end
    end

    drain();
    repeat (300) @(posedge clk);
    $display("Run covered %0d items over directed and 12 random batches; %0d results,",
             items_sent, results_seen);
    $display("%0d of them took a table row.", rows_taken);
    if (mismatches == 0 && outstanding == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

// ===== first_fit_row_packer.f =====
rtl/frp_pkg.sv
rtl/frp_row_mem.sv
rtl/frp_ctrl.sv
rtl/first_fit_row_packer.sv
tb/row_assignment_checker.sv
tb/first_fit_row_packer_test.sv
